// ===== rtl/core/cau_pkg.sv =====
package cau_pkg;

   localparam int FRAC_BITS = 24;
   localparam int DIV_STEPS = 32;
   localparam int NUM_W     = 65 + FRAC_BITS;
   localparam int HI_W      = NUM_W - 32;
   localparam int LATENCY   = 6 + DIV_STEPS;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_OVF  = 2'd1,
      STAT_DIV0 = 2'd2,
      STAT_RSVD = 2'd3
   } status_type;

   typedef struct packed {
      func_type                func;
      logic                    dz;
      logic                    neg_re;
      logic                    neg_im;
      logic                    ovf_re;
      logic                    ovf_im;
      logic [63:0]             den;
      logic [63:0]             rem_re;
      logic [63:0]             rem_im;
      logic [31:0]             num_re;
      logic [31:0]             num_im;
      logic [31:0]             q_re;
      logic [31:0]             q_im;
      logic signed [64:0]      val_re;
      logic signed [64:0]      val_im;
   } div_ctx_type;

   function automatic logic [32:0] sat32(input logic signed [64:0] v);
      logic [32:0] r;
      if (v > 65'sd2147483647) begin
         r = {1'b1, 32'h7fff_ffff};
      end else if (v < -65'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/cau_div_step.sv =====
module cau_div_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  cau_pkg::div_ctx_type  in_ctx,
   output logic                  out_valid,
   output cau_pkg::div_ctx_type  out_ctx
);

   logic                 valid_ff;
   cau_pkg::div_ctx_type ctx_ff;
   cau_pkg::div_ctx_type ctx_in;
   logic [64:0]          trial_re;
   logic [64:0]          trial_im;
   logic                 ge_re;
   logic                 ge_im;
   logic [64:0]          diff_re;
   logic [64:0]          diff_im;

   always_comb begin
      trial_re = {in_ctx.rem_re, in_ctx.num_re[31]};
      trial_im = {in_ctx.rem_im, in_ctx.num_im[31]};
      ge_re    = trial_re >= {1'b0, in_ctx.den};
      ge_im    = trial_im >= {1'b0, in_ctx.den};
      diff_re  = trial_re - {1'b0, in_ctx.den};
      diff_im  = trial_im - {1'b0, in_ctx.den};
      ctx_in        = in_ctx;
      ctx_in.rem_re = ge_re ? diff_re[63:0] : trial_re[63:0];
      ctx_in.rem_im = ge_im ? diff_im[63:0] : trial_im[63:0];
      ctx_in.num_re = {in_ctx.num_re[30:0], 1'b0};
      ctx_in.num_im = {in_ctx.num_im[30:0], 1'b0};
      ctx_in.q_re   = {in_ctx.q_re[30:0], ge_re};
      ctx_in.q_im   = {in_ctx.q_im[30:0], ge_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      ctx_ff <= ctx_in;
   end

   assign out_valid = valid_ff;
   assign out_ctx   = ctx_ff;

endmodule

// ===== rtl/core/complex_arithmetic_unit_top.sv =====
// Complex ALU (add, subtract, multiply, divide) on Q8.24 operands. A word is
// taken on any cycle with start high and busy low; busy is high only during
// reset, so a new word may enter every cycle. Each result appears in order
// after its word has passed 5 setup stages, 32 one-bit divider stages that
// every operation passes through and one output stage, for one cycle with
// rsp_valid high. The receiver cannot stall: capture it then.
module complex_arithmetic_unit_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_res_re,
   output logic signed [31:0] rsp_res_im,
   output logic [1:0]         rsp_status
);

   localparam int F = cau_pkg::FRAC_BITS;

   logic accept;

   logic                s1_valid_ff;
   cau_pkg::func_type   s1_func_ff;
   logic signed [31:0]  s1_ar_ff, s1_ai_ff, s1_br_ff, s1_bi_ff;

   logic                s2_valid_ff;
   cau_pkg::func_type   s2_func_ff;
   logic                s2_dz_ff;
   logic signed [63:0]  s2_rr_ff, s2_ii_ff, s2_ri_ff, s2_ir_ff;
   logic [63:0]         s2_bbr_ff, s2_bbi_ff;
   logic signed [32:0]  s2_add_re_ff, s2_add_im_ff, s2_sub_re_ff, s2_sub_im_ff;

   logic                s3_valid_ff;
   cau_pkg::func_type   s3_func_ff;
   logic                s3_dz_ff;
   logic signed [64:0]  s3_v_re_ff, s3_v_im_ff;
   logic signed [64:0]  s3_v_re_in, s3_v_im_in;
   logic [63:0]         s3_den_ff;

   logic                s4_valid_ff;
   cau_pkg::func_type   s4_func_ff;
   logic                s4_dz_ff;
   logic signed [64:0]  s4_val_re_ff, s4_val_im_ff;
   logic signed [64:0]  s4_val_re_in, s4_val_im_in;
   logic [64:0]         s4_mag_re_ff, s4_mag_im_ff;
   logic                s4_neg_re_ff, s4_neg_im_ff;
   logic [63:0]         s4_den_ff;

   logic [cau_pkg::NUM_W-1:0] num_re, num_im;
   logic [cau_pkg::HI_W-1:0]  hi_re, hi_im;

   logic                 s5_valid_ff;
   cau_pkg::div_ctx_type s5_ctx_ff;
   cau_pkg::div_ctx_type s5_ctx_in;

   logic                 step_valid [cau_pkg::DIV_STEPS+1];
   cau_pkg::div_ctx_type step_ctx   [cau_pkg::DIV_STEPS+1];

   cau_pkg::div_ctx_type fin;
   logic signed [64:0]   fin_re, fin_im;
   logic [32:0]          sat_re, sat_im;

   logic                 out_valid_ff;
   logic signed [31:0]   out_re_ff, out_im_ff, out_re_in, out_im_in;
   cau_pkg::status_type  out_status_ff, out_status_in;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         out_valid_ff <= step_valid[cau_pkg::DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      s1_func_ff <= cau_pkg::func_type'(req_func);
      s1_ar_ff   <= req_a_re;
      s1_ai_ff   <= req_a_im;
      s1_br_ff   <= req_b_re;
      s1_bi_ff   <= req_b_im;
   end

   always_ff @(posedge clock) begin
      s2_func_ff   <= s1_func_ff;
      s2_dz_ff     <= (s1_br_ff == 32'sd0) && (s1_bi_ff == 32'sd0);
      s2_rr_ff     <= s1_ar_ff * s1_br_ff;
      s2_ii_ff     <= s1_ai_ff * s1_bi_ff;
      s2_ri_ff     <= s1_ar_ff * s1_bi_ff;
      s2_ir_ff     <= s1_ai_ff * s1_br_ff;
      s2_bbr_ff    <= 64'(s1_br_ff * s1_br_ff);
      s2_bbi_ff    <= 64'(s1_bi_ff * s1_bi_ff);
      s2_add_re_ff <= 33'(s1_ar_ff) + 33'(s1_br_ff);
      s2_add_im_ff <= 33'(s1_ai_ff) + 33'(s1_bi_ff);
      s2_sub_re_ff <= 33'(s1_ar_ff) - 33'(s1_br_ff);
      s2_sub_im_ff <= 33'(s1_ai_ff) - 33'(s1_bi_ff);
   end

   always_comb begin
      case (s2_func_ff)
         cau_pkg::FUNC_ADD: begin
            s3_v_re_in = 65'(s2_add_re_ff);
            s3_v_im_in = 65'(s2_add_im_ff);
         end
         cau_pkg::FUNC_SUB: begin
            s3_v_re_in = 65'(s2_sub_re_ff);
            s3_v_im_in = 65'(s2_sub_im_ff);
         end
         cau_pkg::FUNC_MUL: begin
            s3_v_re_in = 65'(s2_rr_ff) - 65'(s2_ii_ff);
            s3_v_im_in = 65'(s2_ri_ff) + 65'(s2_ir_ff);
         end
         default: begin
            s3_v_re_in = 65'(s2_rr_ff) + 65'(s2_ii_ff);
            s3_v_im_in = 65'(s2_ir_ff) - 65'(s2_ri_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s3_func_ff <= s2_func_ff;
      s3_dz_ff   <= s2_dz_ff;
      s3_v_re_ff <= s3_v_re_in;
      s3_v_im_ff <= s3_v_im_in;
      s3_den_ff  <= s2_bbr_ff + s2_bbi_ff;
   end

   always_comb begin
      if (s3_func_ff == cau_pkg::FUNC_MUL) begin
         s4_val_re_in = s3_v_re_ff >>> F;
         s4_val_im_in = s3_v_im_ff >>> F;
      end else begin
         s4_val_re_in = s3_v_re_ff;
         s4_val_im_in = s3_v_im_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_func_ff   <= s3_func_ff;
      s4_dz_ff     <= s3_dz_ff;
      s4_val_re_ff <= s4_val_re_in;
      s4_val_im_ff <= s4_val_im_in;
      s4_neg_re_ff <= s3_v_re_ff[64];
      s4_neg_im_ff <= s3_v_im_ff[64];
      s4_mag_re_ff <= s3_v_re_ff[64] ? 65'(-s3_v_re_ff) : 65'(s3_v_re_ff);
      s4_mag_im_ff <= s3_v_im_ff[64] ? 65'(-s3_v_im_ff) : 65'(s3_v_im_ff);
      s4_den_ff    <= s3_den_ff;
   end

   always_comb begin
      num_re = {s4_mag_re_ff, {F{1'b0}}};
      num_im = {s4_mag_im_ff, {F{1'b0}}};
      hi_re  = num_re[cau_pkg::NUM_W-1:32];
      hi_im  = num_im[cau_pkg::NUM_W-1:32];
      s5_ctx_in        = '0;
      s5_ctx_in.func   = s4_func_ff;
      s5_ctx_in.dz     = s4_dz_ff;
      s5_ctx_in.neg_re = s4_neg_re_ff;
      s5_ctx_in.neg_im = s4_neg_im_ff;
      s5_ctx_in.ovf_re = 64'(hi_re) >= s4_den_ff;
      s5_ctx_in.ovf_im = 64'(hi_im) >= s4_den_ff;
      s5_ctx_in.den    = s4_den_ff;
      s5_ctx_in.rem_re = 64'(hi_re);
      s5_ctx_in.rem_im = 64'(hi_im);
      s5_ctx_in.num_re = num_re[31:0];
      s5_ctx_in.num_im = num_im[31:0];
      s5_ctx_in.val_re = s4_val_re_ff;
      s5_ctx_in.val_im = s4_val_im_ff;
   end

   always_ff @(posedge clock) begin
      s5_ctx_ff <= s5_ctx_in;
   end

   assign step_valid[0] = s5_valid_ff;
   assign step_ctx[0]   = s5_ctx_ff;

   for (genvar g = 0; g < cau_pkg::DIV_STEPS; g++) begin : g_div
      cau_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (step_valid[g]),
         .in_ctx    (step_ctx[g]),
         .out_valid (step_valid[g+1]),
         .out_ctx   (step_ctx[g+1])
      );
   end

   always_comb begin
      fin = step_ctx[cau_pkg::DIV_STEPS];
      if (fin.func == cau_pkg::FUNC_DIV) begin
         fin_re = fin.neg_re ? -65'(fin.q_re) : 65'(fin.q_re);
         fin_im = fin.neg_im ? -65'(fin.q_im) : 65'(fin.q_im);
         if (fin.ovf_re) begin
            fin_re = fin.neg_re ? -65'sd4294967296 : 65'sd4294967296;
         end
         if (fin.ovf_im) begin
            fin_im = fin.neg_im ? -65'sd4294967296 : 65'sd4294967296;
         end
      end else begin
         fin_re = fin.val_re;
         fin_im = fin.val_im;
      end
      sat_re = cau_pkg::sat32(fin_re);
      sat_im = cau_pkg::sat32(fin_im);
      if (fin.func == cau_pkg::FUNC_DIV && fin.dz) begin
         out_re_in     = 32'sd0;
         out_im_in     = 32'sd0;
         out_status_in = cau_pkg::STAT_DIV0;
      end else begin
         out_re_in     = sat_re[31:0];
         out_im_in     = sat_im[31:0];
         out_status_in = (sat_re[32] || sat_im[32]) ? cau_pkg::STAT_OVF : cau_pkg::STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      out_re_ff     <= out_re_in;
      out_im_ff     <= out_im_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_res_re = out_re_ff;
   assign rsp_res_im = out_im_ff;
   assign rsp_status = out_status_ff;

   a_latency_hit: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(cau_pkg::LATENCY) rsp_valid)
      else $error("result missing after fixed latency");

   a_latency_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##(cau_pkg::LATENCY) !rsp_valid)
      else $error("result without accepted word");

   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cau_pkg::STAT_DIV0) |->
         (rsp_res_re == 32'sd0 && rsp_res_im == 32'sd0))
      else $error("divide by zero with nonzero parts");

   a_no_rsvd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != cau_pkg::STAT_RSVD)
      else $error("reserved status code");

endmodule

// ===== sim/cau_result_checker.sv =====
module cau_result_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_res_re,
   input  logic signed [31:0] rsp_res_im,
   input  logic [1:0]         rsp_status,
   output int                 mismatch_count,
   output int                 pending_count
);

   typedef struct {
      logic signed [31:0]  res_re;
      logic signed [31:0]  res_im;
      cau_pkg::status_type status;
   } cplx_result_type;

   cplx_result_type expected_results[$];

   function automatic logic signed [31:0] clamp_part(input logic signed [127:0] v,
                                                     inout logic ovf);
      if (v > 128'sd2147483647) begin
         ovf = 1'b1;
         return 32'h7fff_ffff;
      end
      if (v < -128'sd2147483648) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic cplx_result_type predict_complex_op(
      input cau_pkg::func_type op, input logic signed [31:0] a_re, a_im, b_re, b_im);
      cplx_result_type r;
      logic signed [127:0] ar, ai, br, bi, re, im, den;
      logic ovf;
      ar = a_re;
      ai = a_im;
      br = b_re;
      bi = b_im;
      ovf = 1'b0;
      case (op)
         cau_pkg::FUNC_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         cau_pkg::FUNC_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         cau_pkg::FUNC_MUL: begin
            re = (ar * br - ai * bi) >>> cau_pkg::FRAC_BITS;
            im = (ar * bi + ai * br) >>> cau_pkg::FRAC_BITS;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.res_re = '0;
               r.res_im = '0;
               r.status = cau_pkg::STAT_DIV0;
               return r;
            end
            re = ((ar * br + ai * bi) <<< cau_pkg::FRAC_BITS) / den;
            im = ((ai * br - ar * bi) <<< cau_pkg::FRAC_BITS) / den;
         end
      endcase
      r.res_re = clamp_part(re, ovf);
      r.res_im = clamp_part(im, ovf);
      r.status = ovf ? cau_pkg::STAT_OVF : cau_pkg::STAT_OK;
      return r;
   endfunction

   assign pending_count = expected_results.size();

   initial mismatch_count = 0;

   always @(posedge clock) begin
      cplx_result_type exp_r;
      if (!reset && start && !busy) begin
         expected_results.push_back(
            predict_complex_op(cau_pkg::func_type'(req_func), req_a_re,
                               req_a_im, req_b_re, req_b_im));
      end
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result word re=%0d im=%0d status=%0d",
                        rsp_res_re, rsp_res_im, rsp_status);
            end
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_res_re !== exp_r.res_re || rsp_res_im !== exp_r.res_im ||
                rsp_status !== exp_r.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: exp re=%0d im=%0d status=%0d got re=%0d im=%0d status=%0d",
                           exp_r.res_re, exp_r.res_im, exp_r.status,
                           rsp_res_re, rsp_res_im, rsp_status);
               end
            end
         end
      end
   end

endmodule

// ===== sim/complex_arithmetic_unit_top_test.sv =====
module complex_arithmetic_unit_top_test;

   localparam int NUM_RANDOM  = 1350;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_func;
   logic signed [31:0] req_a_re;
   logic signed [31:0] req_a_im;
   logic signed [31:0] req_b_re;
   logic signed [31:0] req_b_im;
   logic               rsp_valid;
   logic signed [31:0] rsp_res_re;
   logic signed [31:0] rsp_res_im;
   logic [1:0]         rsp_status;
   int                 mismatch_count;
   int                 pending_count;
   int                 cycle_count;

   complex_arithmetic_unit_top u_top (.*);

   cau_result_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("complex_arithmetic_unit_top test failed");
         $finish;
      end
   end

   function automatic logic [31:0] pick_part();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
         7:          return '0;
         8: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0001;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom_range(0, 1) ? 32'h0100_0000 : 32'hff00_0000;
      endcase
   endfunction

   task automatic send_word(input cau_pkg::func_type op, input logic [31:0] ar, ai, br, bi,
                            input bit may_idle);
      if (may_idle) begin
         while ($urandom_range(0, 99) < 19) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_func <= op;
      req_a_re <= ar;
      req_a_im <= ai;
      req_b_re <= br;
      req_b_im <= bi;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      cau_pkg::func_type op;
      logic [31:0] br, bi;
      start    <= 1'b0;
      req_func <= cau_pkg::FUNC_ADD;
      req_a_re <= '0;
      req_a_im <= '0;
      req_b_re <= '0;
      req_b_im <= '0;
      reset    <= 1'b1;
      repeat (6) @(posedge clock);
      reset    <= 1'b0;
      @(posedge clock);

      send_word(cau_pkg::FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff, 0);
      send_word(cau_pkg::FUNC_ADD, 32'h0100_0000, 32'h0200_0000, 32'hff00_0000, 32'h0300_0000, 0);
      send_word(cau_pkg::FUNC_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff, 0);
      send_word(cau_pkg::FUNC_SUB, 32'h0100_0000, 32'h0000_0000, 32'h0100_0000, 32'h0000_0000, 0);
      send_word(cau_pkg::FUNC_MUL, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'hff00_0000, 0);
      send_word(cau_pkg::FUNC_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
      send_word(cau_pkg::FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_word(cau_pkg::FUNC_MUL, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 0);
      send_word(cau_pkg::FUNC_DIV, 32'h0100_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
      send_word(cau_pkg::FUNC_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
      send_word(cau_pkg::FUNC_DIV, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'hff00_0000, 0);
      send_word(cau_pkg::FUNC_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 0);
      send_word(cau_pkg::FUNC_DIV, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0003, 32'h0000_0000, 0);
      send_word(cau_pkg::FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_word(cau_pkg::FUNC_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      send_word(cau_pkg::FUNC_DIV, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 0);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         op = cau_pkg::func_type'($urandom_range(0, 3));
         br = pick_part();
         bi = pick_part();
         if (op == cau_pkg::FUNC_DIV && $urandom_range(0, 19) == 0) begin
            br = '0;
            bi = '0;
         end
         send_word(op, pick_part(), pick_part(), br, bi, !(i >= 600 && i < 800));
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (cau_pkg::LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("complex_arithmetic_unit_top test passed");
      end else begin
         $display("complex_arithmetic_unit_top test failed");
      end
      $finish;
   end

endmodule

// ===== complex_arithmetic_unit_top.f =====
rtl/core/cau_pkg.sv
rtl/core/cau_div_step.sv
rtl/core/complex_arithmetic_unit_top.sv
sim/cau_result_checker.sv
sim/complex_arithmetic_unit_top_test.sv
